// ----- rtl/rau_pkg.sv -----
package rau_pkg;

	localparam logic [3:0] FUNC_ADD = 4'd0;
	localparam logic [3:0] FUNC_SUB = 4'd1;
	localparam logic [3:0] FUNC_MUL = 4'd2;
	localparam logic [3:0] FUNC_DIV = 4'd3;
	localparam logic [3:0] FUNC_EQ  = 4'd4;
	localparam logic [3:0] FUNC_NE  = 4'd5;
	localparam logic [3:0] FUNC_LT  = 4'd6;
	localparam logic [3:0] FUNC_GT  = 4'd7;
	localparam logic [3:0] FUNC_LE  = 4'd8;
	localparam logic [3:0] FUNC_GE  = 4'd9;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_DEN_ZERO = 2'd1;
	localparam logic [1:0] ST_DIV_ZERO = 2'd2;

	localparam int NUM_W = 33;
	localparam int DEN_W = 31;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_MUL0,
		S_MUL1,
		S_MUL2,
		S_COMBINE,
		S_GCD,
		S_DIVIDE,
		S_OUTPUT
	} state_t;

	typedef enum logic [1:0] {
		MS_NUM,
		MS_DEN,
		MS_CROSS
	} mul_step_t;

	typedef enum logic [2:0] {
		RS_DEN_ZERO,
		RS_DIV_ZERO,
		RS_BAD_FUNC,
		RS_CMP,
		RS_ARITH
	} res_sel_t;

	typedef struct packed {
		logic      load;
		logic      mul_en;
		mul_step_t mul_step;
		logic      combine;
		logic      gcd_en;
		logic      div_init;
		logic      div_en;
		logic      res_en;
		res_sel_t  res_sel;
	} rau_cmd_t;

	typedef struct packed {
		logic den_zero;
		logic div_zero;
		logic bad_func;
		logic is_cmp;
		logic gcd_done;
		logic div_done;
	} rau_stat_t;

endpackage

// ----- rtl/rau_ctrl.sv -----
module rau_ctrl import rau_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  rau_stat_t stat,
	output rau_cmd_t  cmd,
	output logic      busy,
	output logic      done
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_nxt = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.den_zero || stat.div_zero || stat.bad_func) begin
					state_nxt = S_OUTPUT;
				end else begin
					state_nxt = S_MUL0;
				end
			end
			S_MUL0: state_nxt = S_MUL1;
			S_MUL1: state_nxt = S_MUL2;
			S_MUL2: state_nxt = S_COMBINE;
			S_COMBINE: begin
				if (stat.is_cmp) begin
					state_nxt = S_OUTPUT;
				end else begin
					state_nxt = S_GCD;
				end
			end
			S_GCD: begin
				if (stat.gcd_done) begin
					state_nxt = S_DIVIDE;
				end
			end
			S_DIVIDE: begin
				if (stat.div_done) begin
					state_nxt = S_OUTPUT;
				end
			end
			S_OUTPUT: state_nxt = S_IDLE;
			default:  state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.mul_step = MS_NUM;
		cmd.res_sel  = RS_ARITH;
		busy         = 1'b1;
		done         = 1'b0;
		case (state_q)
			S_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			S_CHECK: begin
				if (stat.den_zero) begin
					cmd.res_en  = 1'b1;
					cmd.res_sel = RS_DEN_ZERO;
				end else if (stat.div_zero) begin
					cmd.res_en  = 1'b1;
					cmd.res_sel = RS_DIV_ZERO;
				end else if (stat.bad_func) begin
					cmd.res_en  = 1'b1;
					cmd.res_sel = RS_BAD_FUNC;
				end
			end
			S_MUL0: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_step = MS_NUM;
			end
			S_MUL1: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_step = MS_DEN;
			end
			S_MUL2: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_step = MS_CROSS;
			end
			S_COMBINE: begin
				if (stat.is_cmp) begin
					cmd.res_en  = 1'b1;
					cmd.res_sel = RS_CMP;
				end else begin
					cmd.combine = 1'b1;
				end
			end
			S_GCD: begin
				if (stat.gcd_done) begin
					cmd.div_init = 1'b1;
				end else begin
					cmd.gcd_en = 1'b1;
				end
			end
			S_DIVIDE: begin
				if (stat.div_done) begin
					cmd.res_en  = 1'b1;
					cmd.res_sel = RS_ARITH;
				end else begin
					cmd.div_en = 1'b1;
				end
			end
			S_OUTPUT: begin
				done = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

// ----- rtl/rau_datapath.sv -----
module rau_datapath import rau_pkg::*; #(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic                     clk,
	input  rau_cmd_t                 cmd,
	input  logic [3:0]               func,
	input  logic [OPERAND_WIDTH-1:0] a_num,
	input  logic [OPERAND_WIDTH-1:0] a_den,
	input  logic [OPERAND_WIDTH-1:0] b_num,
	input  logic [OPERAND_WIDTH-1:0] b_den,
	output rau_stat_t                stat,
	output logic [NUM_W-1:0]         res_num,
	output logic [DEN_W-1:0]         res_den,
	output logic                     cmp_true,
	output logic [1:0]               status
);

	localparam int W  = OPERAND_WIDTH;
	localparam int PW = 2 * W;
	localparam int KW = $clog2(PW + 1);
	localparam int XW = (PW > NUM_W) ? PW : NUM_W;

	logic [3:0]    func_q;
	logic [W-1:0]  an_mag_q, ad_mag_q, bn_mag_q, bd_mag_q;
	logic          an_neg_q, bn_neg_q;
	logic [PW-1:0] p0_q, p1_q, p2_q;
	logic [PW-1:0] nm_q, dm_q;
	logic          num_neg_q;
	logic [PW-1:0] u_q, v_q;
	logic [KW-1:0] k_q;
	logic [PW-1:0] g_q;
	logic [PW-1:0] nq_q, dq_q, nr_q, dr_q;
	logic [KW-1:0] cnt_q;

	logic [NUM_W-1:0] res_num_q;
	logic [DEN_W-1:0] res_den_q;
	logic             cmp_true_q;
	logic [1:0]       status_q;

	logic [NUM_W-1:0] res_num_nxt;
	logic [DEN_W-1:0] res_den_nxt;
	logic             cmp_true_nxt;
	logic [1:0]       status_nxt;

	function automatic logic [W-1:0] mag_of(input logic [W-1:0] raw);
		return raw[W-1] ? (~raw + 1'b1) : raw;
	endfunction

	logic [W-1:0]  mul_a, mul_b;
	logic [PW-1:0] prod;

	always_comb begin
		mul_a = an_mag_q;
		mul_b = bd_mag_q;
		case (cmd.mul_step)
			MS_NUM: begin
				mul_a = an_mag_q;
				mul_b = (func_q == FUNC_MUL) ? bn_mag_q : bd_mag_q;
			end
			MS_DEN: begin
				mul_a = ad_mag_q;
				mul_b = (func_q == FUNC_DIV) ? bn_mag_q : bd_mag_q;
			end
			MS_CROSS: begin
				mul_a = bn_mag_q;
				mul_b = ad_mag_q;
			end
			default: begin
				mul_a = an_mag_q;
				mul_b = bd_mag_q;
			end
		endcase
	end

	assign prod = {{W{1'b0}}, mul_a} * {{W{1'b0}}, mul_b};

	logic          r_neg;
	logic [PW-1:0] num_mag;
	logic          num_neg;

	always_comb begin
		r_neg = bn_neg_q ^ (func_q == FUNC_SUB);
		if (func_q == FUNC_MUL || func_q == FUNC_DIV) begin
			num_mag = p0_q;
			num_neg = an_neg_q ^ bn_neg_q;
		end else if (an_neg_q == r_neg) begin
			num_mag = p0_q + p2_q;
			num_neg = an_neg_q;
		end else if (p0_q >= p2_q) begin
			num_mag = p0_q - p2_q;
			num_neg = an_neg_q;
		end else begin
			num_mag = p2_q - p0_q;
			num_neg = r_neg;
		end
	end

	logic l_neg, rc_neg, c_eq, c_lt, holds;

	always_comb begin
		l_neg  = an_neg_q && (an_mag_q != '0);
		rc_neg = bn_neg_q && (bn_mag_q != '0);
		if (l_neg != rc_neg) begin
			c_eq = 1'b0;
			c_lt = l_neg;
		end else if (p0_q == p2_q) begin
			c_eq = 1'b1;
			c_lt = 1'b0;
		end else begin
			c_eq = 1'b0;
			c_lt = l_neg ? (p0_q > p2_q) : (p0_q < p2_q);
		end
		case (func_q)
			FUNC_EQ: holds = c_eq;
			FUNC_NE: holds = !c_eq;
			FUNC_LT: holds = c_lt;
			FUNC_GT: holds = !c_lt && !c_eq;
			FUNC_LE: holds = c_lt || c_eq;
			FUNC_GE: holds = !c_lt;
			default: holds = 1'b0;
		endcase
	end

	logic [PW:0] nr_sh, dr_sh;
	logic        n_ge, d_ge;

	assign nr_sh = {nr_q, nq_q[PW-1]};
	assign dr_sh = {dr_q, dq_q[PW-1]};
	assign n_ge  = nr_sh >= {1'b0, g_q};
	assign d_ge  = dr_sh >= {1'b0, g_q};

	logic [XW-1:0] num_ext, num_sgn, den_ext;

	assign num_ext = XW'(nq_q);
	assign num_sgn = num_neg_q ? (~num_ext + 1'b1) : num_ext;
	assign den_ext = XW'(dq_q);

	always_comb begin
		res_num_nxt  = '0;
		res_den_nxt  = DEN_W'(1);
		cmp_true_nxt = 1'b0;
		status_nxt   = ST_OK;
		case (cmd.res_sel)
			RS_DEN_ZERO: status_nxt = ST_DEN_ZERO;
			RS_DIV_ZERO: status_nxt = ST_DIV_ZERO;
			RS_BAD_FUNC: status_nxt = ST_OK;
			RS_CMP:      cmp_true_nxt = holds;
			RS_ARITH: begin
				res_num_nxt = num_sgn[NUM_W-1:0];
				res_den_nxt = den_ext[DEN_W-1:0];
			end
			default: status_nxt = ST_OK;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q   <= func;
			an_mag_q <= mag_of(a_num);
			ad_mag_q <= mag_of(a_den);
			bn_mag_q <= mag_of(b_num);
			bd_mag_q <= mag_of(b_den);
			an_neg_q <= a_num[W-1] ^ a_den[W-1];
			bn_neg_q <= b_num[W-1] ^ b_den[W-1];
		end

		if (cmd.mul_en) begin
			case (cmd.mul_step)
				MS_NUM:   p0_q <= prod;
				MS_DEN:   p1_q <= prod;
				MS_CROSS: p2_q <= prod;
				default:  p0_q <= prod;
			endcase
		end

		if (cmd.combine) begin
			nm_q      <= num_mag;
			dm_q      <= p1_q;
			num_neg_q <= num_neg;
			u_q       <= num_mag;
			v_q       <= p1_q;
			k_q       <= '0;
		end else if (cmd.gcd_en) begin
			if (!u_q[0] && !v_q[0]) begin
				u_q <= u_q >> 1;
				v_q <= v_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!u_q[0]) begin
				u_q <= u_q >> 1;
			end else if (!v_q[0]) begin
				v_q <= v_q >> 1;
			end else if (u_q >= v_q) begin
				u_q <= (u_q - v_q) >> 1;
			end else begin
				v_q <= (v_q - u_q) >> 1;
			end
		end

		if (cmd.div_init) begin
			g_q   <= (u_q | v_q) << k_q;
			nq_q  <= nm_q;
			dq_q  <= dm_q;
			nr_q  <= '0;
			dr_q  <= '0;
			cnt_q <= '0;
		end else if (cmd.div_en) begin
			nr_q  <= n_ge ? PW'(nr_sh - {1'b0, g_q}) : PW'(nr_sh);
			dr_q  <= d_ge ? PW'(dr_sh - {1'b0, g_q}) : PW'(dr_sh);
			nq_q  <= {nq_q[PW-2:0], n_ge};
			dq_q  <= {dq_q[PW-2:0], d_ge};
			cnt_q <= cnt_q + 1'b1;
		end

		if (cmd.res_en) begin
			res_num_q  <= res_num_nxt;
			res_den_q  <= res_den_nxt;
			cmp_true_q <= cmp_true_nxt;
			status_q   <= status_nxt;
		end
	end

	always_comb begin
		stat.den_zero = (ad_mag_q == '0) || (bd_mag_q == '0);
		stat.div_zero = (func_q == FUNC_DIV) && (bn_mag_q == '0);
		stat.bad_func = func_q > FUNC_GE;
		stat.is_cmp   = (func_q >= FUNC_EQ) && (func_q <= FUNC_GE);
		stat.gcd_done = (u_q == '0) || (v_q == '0);
		stat.div_done = cnt_q == KW'(PW);
	end

	assign res_num  = res_num_q;
	assign res_den  = res_den_q;
	assign cmp_true = cmp_true_q;
	assign status   = status_q;

endmodule

// ----- rtl/rational_arithmetic_unit_core.sv -----
// Rational arithmetic unit: add, sub, mul, div or compare of two signed fractions.
// Input channel: drive func and the four operand ports and raise start; the
// transaction is taken at the rising edge where start is high and busy is low.
// Operands are sampled at that edge and may change afterwards.
// Output channel: done is high for exactly one cycle while res_num, res_den,
// cmp_true and status carry the result; the receiver has no way to stall it.
// Steps from the accepting edge to the edge that takes the result:
//   zero denominator, divide by zero, unused func: S_CHECK, then S_OUTPUT
//   compares: S_CHECK, S_MUL0, S_MUL1, S_MUL2, S_COMBINE, then S_OUTPUT
//   arithmetic: as compares up to S_COMBINE, then binary gcd steps in S_GCD
//   and a restoring divide in S_DIVIDE that reduces numerator and
//   denominator in parallel by the gcd, then S_OUTPUT.
// One multiplier is shared by S_MUL0, S_MUL1 and S_MUL2 for the products.
// busy stays high from accept through the done cycle and drops the cycle after;
// one transaction at a time, so a new item is taken only once busy has dropped.
// Reset (arst_n low) returns the controller to idle at once; an item in flight is
// dropped and no done is given for it.
module rational_arithmetic_unit_core import rau_pkg::*; #(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [3:0]                      func,
	input  logic signed [OPERAND_WIDTH-1:0] a_num,
	input  logic signed [OPERAND_WIDTH-1:0] a_den,
	input  logic signed [OPERAND_WIDTH-1:0] b_num,
	input  logic signed [OPERAND_WIDTH-1:0] b_den,
	output logic                            done,
	output logic signed [NUM_W-1:0]         res_num,
	output logic [DEN_W-1:0]                res_den,
	output logic                            cmp_true,
	output logic [1:0]                      status
);

	rau_cmd_t  cmd;
	rau_stat_t stat;
	logic [NUM_W-1:0] res_num_raw;

	rau_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	rau_datapath #(
		.OPERAND_WIDTH (OPERAND_WIDTH)
	) u_datapath (
		.clk      (clk),
		.cmd      (cmd),
		.func     (func),
		.a_num    (a_num),
		.a_den    (a_den),
		.b_num    (b_num),
		.b_den    (b_den),
		.stat     (stat),
		.res_num  (res_num_raw),
		.res_den  (res_den),
		.cmp_true (cmp_true),
		.status   (status)
	);

	assign res_num = res_num_raw;

endmodule
